/* design/tkit_pkg.sv */
// Shared types and constants for the top-k insertion tracker.
// No dependencies; used by every module of the block.
`default_nettype none

package tkit_pkg;

   localparam int WORD_W = 48;
   localparam int ID_W   = 16;
   localparam int RANK_W = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [ID_W-1:0]   id_type;
   typedef logic [RANK_W-1:0] rank_type;

   // controller to datapath
   typedef struct packed {
      logic insert;       // place the request entry into the table
      logic drain_start;  // restart the rank counter
      logic emit;         // load the result register from the table head
   } tkit_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fill_zero;    // table holds no entries
      logic fill_le1;     // table holds at most one entry
      logic out_free;     // result register can take a new transaction
   } tkit_status_type;

endpackage

`default_nettype wire

/* design/top_k_insertion_tracker.sv */
// Top-k insertion tracker: keeps the TOP_N entries with the largest word count.
// Insert: one transaction per cycle while idle; no result.
// Drain: the drain state loads the first result, then one per cycle as the
//   sink takes them; the block is busy for max(fill,1) result transactions.
// Reset (synchronous) empties the table and clears the result channel.
// Depends on tkit_pkg, tkit_ctrl and tkit_dp.
`default_nettype none

module top_k_insertion_tracker #(
   parameter int TOP_N = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire tkit_pkg::word_type req_word_count,
   input  wire tkit_pkg::word_type req_cell_count,
   input  wire tkit_pkg::id_type   req_entry_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output tkit_pkg::word_type      rsp_out_words,
   output tkit_pkg::word_type      rsp_out_cells,
   output tkit_pkg::id_type        rsp_out_id,
   output tkit_pkg::rank_type      rsp_rank,
   output logic                    rsp_last,
   output logic                    rsp_empty_res
);

   // Commands from the controller, status back from the datapath.
   tkit_pkg::tkit_cmd_type    cmd;
   tkit_pkg::tkit_status_type status;

   // The controller decides when a request transaction is taken and when
   // the result register is loaded during a drain.
   tkit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the ranked row of cells: on insert every cell
   // compares its key with the new one in parallel and either holds, takes
   // the new entry or takes its upper neighbour. On drain the row advances
   // to the head one place per result transaction.
   tkit_dp #(
      .TOP_N (TOP_N)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_word_count (req_word_count),
      .req_cell_count (req_cell_count),
      .req_entry_id   (req_entry_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_words  (rsp_out_words),
      .rsp_out_cells  (rsp_out_cells),
      .rsp_out_id     (rsp_out_id),
      .rsp_rank       (rsp_rank),
      .rsp_last       (rsp_last),
      .rsp_empty_res  (rsp_empty_res)
   );

endmodule

`default_nettype wire

/* design/tkit_ctrl.sv */
// Controller for the top-k insertion tracker: idle and drain sequencing.
// Depends on tkit_pkg for the command and status structs.
`default_nettype none

module tkit_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_cmd,
   output logic                           req_ready,
   input  wire tkit_pkg::tkit_status_type status,
   output tkit_pkg::tkit_cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in        = state_ff;
      cmd.insert      = 1'b0;
      cmd.drain_start = 1'b0;
      cmd.emit        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == tkit_pkg::CMD_INSERT)) begin
               cmd.insert = 1'b1;
            end
            if (accept && (req_cmd == tkit_pkg::CMD_DRAIN)) begin
               cmd.drain_start = 1'b1;
               state_in        = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.emit = status.out_free;
            // leave once the final entry (or the empty marker) is loaded
            if (status.out_free && status.fill_le1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/tkit_dp.sv */
// Datapath for the top-k insertion tracker: ranked cell row, fill count,
// rank counter and result register. Depends on tkit_pkg.
`default_nettype none

module tkit_dp #(
   parameter int TOP_N = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tkit_pkg::tkit_cmd_type cmd,
   output tkit_pkg::tkit_status_type   status,
   input  wire tkit_pkg::word_type     req_word_count,
   input  wire tkit_pkg::word_type     req_cell_count,
   input  wire tkit_pkg::id_type       req_entry_id,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tkit_pkg::word_type          rsp_out_words,
   output tkit_pkg::word_type          rsp_out_cells,
   output tkit_pkg::id_type            rsp_out_id,
   output tkit_pkg::rank_type          rsp_rank,
   output logic                        rsp_last,
   output logic                        rsp_empty_res
);

   localparam int FILL_W = $clog2(TOP_N + 1);
   localparam int CNT_W  = (TOP_N > 1) ? $clog2(TOP_N) : 1;

   tkit_pkg::word_type key_ff  [TOP_N];
   tkit_pkg::word_type key_in  [TOP_N];
   tkit_pkg::word_type cell_ff [TOP_N];
   tkit_pkg::word_type cell_in [TOP_N];
   tkit_pkg::id_type   id_ff   [TOP_N];
   tkit_pkg::id_type   id_in   [TOP_N];
   logic [TOP_N-1:0]   ge;

   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]   rank_cnt_ff, rank_cnt_in;
   logic               do_insert;

   logic               rsp_valid_ff, rsp_valid_in;
   tkit_pkg::word_type rsp_words_ff, rsp_words_in;
   tkit_pkg::word_type rsp_cells_ff, rsp_cells_in;
   tkit_pkg::id_type   rsp_id_ff, rsp_id_in;
   tkit_pkg::rank_type rsp_rank_ff, rsp_rank_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_empty_ff, rsp_empty_in;

   assign do_insert = cmd.insert && (req_word_count != '0);

   // held entries that stay ahead of the new one form a prefix of the row
   always_comb begin
      for (int i = 0; i < TOP_N; i++) begin
         ge[i] = (FILL_W'(i) < fill_ff) && (key_ff[i] >= req_word_count);
      end
   end

   for (genvar g = 0; g < TOP_N; g++) begin : g_cell
      logic prev_ge;
      if (g == 0) begin : g_head
         assign prev_ge = 1'b1;
      end else begin : g_body
         assign prev_ge = ge[g-1];
      end

      always_comb begin
         key_in[g]  = key_ff[g];
         cell_in[g] = cell_ff[g];
         id_in[g]   = id_ff[g];
         if (do_insert && !ge[g]) begin
            if (prev_ge) begin
               key_in[g]  = req_word_count;
               cell_in[g] = req_cell_count;
               id_in[g]   = req_entry_id;
            end else begin
               key_in[g]  = key_ff[(g == 0) ? 0 : g-1];
               cell_in[g] = cell_ff[(g == 0) ? 0 : g-1];
               id_in[g]   = id_ff[(g == 0) ? 0 : g-1];
            end
         end else if (cmd.emit && (g < TOP_N-1)) begin
            // advance the row towards the head during a drain
            key_in[g]  = key_ff[(g < TOP_N-1) ? g+1 : g];
            cell_in[g] = cell_ff[(g < TOP_N-1) ? g+1 : g];
            id_in[g]   = id_ff[(g < TOP_N-1) ? g+1 : g];
         end
      end

      always_ff @(posedge clock) begin
         key_ff[g]  <= key_in[g];
         cell_ff[g] <= cell_in[g];
         id_ff[g]   <= id_in[g];
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (do_insert && (fill_ff < FILL_W'(TOP_N))) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.emit && (fill_ff != '0)) begin
         fill_in = fill_ff - FILL_W'(1);
      end

      rank_cnt_in = rank_cnt_ff;
      if (cmd.drain_start) begin
         rank_cnt_in = '0;
      end else if (cmd.emit) begin
         rank_cnt_in = rank_cnt_ff + CNT_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_words_in = rsp_words_ff;
      rsp_cells_in = rsp_cells_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      if (cmd.emit) begin
         rsp_empty_in = status.fill_zero;
         rsp_last_in  = status.fill_le1;
         if (status.fill_zero) begin
            rsp_words_in = '0;
            rsp_cells_in = '0;
            rsp_id_in    = '0;
            rsp_rank_in  = '0;
         end else begin
            rsp_words_in = key_ff[0];
            rsp_cells_in = cell_ff[0];
            rsp_id_in    = id_ff[0];
            rsp_rank_in  = tkit_pkg::rank_type'(rank_cnt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rank_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rank_cnt_ff  <= rank_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_words_ff <= rsp_words_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign status.fill_zero = (fill_ff == '0);
   assign status.fill_le1  = (fill_ff <= FILL_W'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_words = rsp_words_ff;
   assign rsp_out_cells = rsp_cells_ff;
   assign rsp_out_id    = rsp_id_ff;
   assign rsp_rank      = rsp_rank_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule

`default_nettype wire

/* design/tkit_checker.sv */
// Port-level checks for the top-k insertion tracker, bound to the top level.
// Depends on tkit_pkg and top_k_insertion_tracker.
`default_nettype none

module tkit_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire tkit_pkg::word_type rsp_out_words,
   input wire tkit_pkg::word_type rsp_out_cells,
   input wire tkit_pkg::id_type   rsp_out_id,
   input wire tkit_pkg::rank_type rsp_rank,
   input wire logic               rsp_last,
   input wire logic               rsp_empty_res
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_words)
         && $stable(rsp_out_id) && $stable(rsp_rank) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_out_words == '0)
         && (rsp_out_cells == '0) && (rsp_rank == '0))
      else $error("empty marker malformed");

   // no new request is taken while a drain still has results to give
   a_busy_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !(req_valid && req_ready))
      else $error("request taken in the middle of a drain");

   a_rank_zero_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || (rsp_rank == '0))
      else $error("drain did not restart at the head");

endmodule

bind top_k_insertion_tracker tkit_checker u_tkit_checker (.*);

`default_nettype wire
